>>> rtl/core/sdtq_pkg.sv
// shared constants, codes and types for the sorted deadline timer queue
`timescale 1ns / 1ps
package sdtq_pkg;

  // default sizes of the timer table
  localparam int MAX_TIMERS_DEF = 16;
  localparam int PID_BITS_DEF   = 16;

  // fixed field widths
  localparam int TICK_W = 64;
  localparam int SEC_W  = 60;
  localparam int PID_W  = 16;
  localparam int WANT_W = 32;
  localparam int KIND_W = 2;

  // most releases one tick can give
  localparam int MAX_OUT = 16;
  localparam int REL_W   = $clog2(MAX_OUT + 1);

  // ticks per second and the width of the sub-second count
  localparam int SECS_DIV = 18;
  localparam int SUB_W    = $clog2(SECS_DIV);

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd3;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // sorted insert of the new entry
    logic shift;  // drop the front entry, move all toward the front
  } cell_ctl_t;

endpackage

>>> rtl/core/sdtq_cell.sv
// one slot of the sorted timer chain: holds an entry, inserts or shifts
`timescale 1ns / 1ps
module sdtq_cell
  import sdtq_pkg::*;
#(
  parameter int PidW = PID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [TICK_W-1:0] new_dl_i,
  input  logic [PidW-1:0]   new_pid_i,
  input  logic              prev_before_i,
  input  logic              prev_valid_i,
  input  logic [TICK_W-1:0] prev_dl_i,
  input  logic [PidW-1:0]   prev_pid_i,
  input  logic              next_valid_i,
  input  logic [TICK_W-1:0] next_dl_i,
  input  logic [PidW-1:0]   next_pid_i,
  output logic              before_o,
  output logic              valid_o,
  output logic [TICK_W-1:0] dl_o,
  output logic [PidW-1:0]   pid_o
);

  logic              valid_q, valid_d;
  logic [TICK_W-1:0] dl_q, dl_d;
  logic [PidW-1:0]   pid_q, pid_d;

  // new entry orders strictly before this one (equal keys go behind)
  assign before_o = !valid_q || (new_dl_i < dl_q) ||
                    ((new_dl_i == dl_q) && (new_pid_i < pid_q));

  // next contents
  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    pid_d   = pid_q;
    if (ctl_i.shift) begin
      valid_d = next_valid_i;
      dl_d    = next_dl_i;
      pid_d   = next_pid_i;
    end else if (ctl_i.ins && before_o) begin
      if (prev_before_i) begin
        valid_d = prev_valid_i;
        dl_d    = prev_dl_i;
        pid_d   = prev_pid_i;
      end else begin
        valid_d = 1'b1;
        dl_d    = new_dl_i;
        pid_d   = new_pid_i;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    pid_q <= pid_d;
  end

  assign valid_o = valid_q;
  assign dl_o    = dl_q;
  assign pid_o   = pid_q;

endmodule

>>> rtl/core/sorted_deadline_timer_queue_core.sv
// top level of the sorted deadline timer queue: control, counters, cell chain
`timescale 1ns / 1ps
// Usage
//   Command channel: drive req_type_i, pid_i and wanted_ticks_i with start high; the
//   word is taken at a rising edge where start is high and busy is low.
//   Result channel: each result word sits on kind_o, released_pid_o, tick_count_o,
//   seconds_count_o and last_o for one cycle while result_valid_o is high;
//   last_o marks the final word of a command. The receiver cannot stall.
//   Command steps:
//     add, table full : result in the cycle after acceptance, busy stays low
//     add             : deadline sum registered, then sorted insert in all
//                       cells at once; busy while the insert is done
//     tick            : counter step, then the due timers are released in order
//                       (the chain shifts toward the front by one slot per cycle),
//                       or a plain tick report if none is due; busy until the
//                       last result word is set
//   A new command can be taken in the cycle its last result is shown.
//   Reset: tick counter and seconds at zero, table empty, no result pending.
//   seconds_count_o is kept by a running divide-by-18 counter, never divided.
module sorted_deadline_timer_queue_core
  import sdtq_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int PID_BITS   = PID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [PID_W-1:0]  pid_i,
  input  logic [WANT_W-1:0] wanted_ticks_i,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] kind_o,
  output logic [PID_W-1:0]  released_pid_o,
  output logic [TICK_W-1:0] tick_count_o,
  output logic [SEC_W-1:0]  seconds_count_o,
  output logic              last_o
);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [SEC_W-1:0]    sec_q, sec_d;
  logic [SUB_W-1:0]    sub_q, sub_d;
  logic [REL_W-1:0]    rel_q, rel_d;
  logic [TICK_W-1:0]   new_dl_q, new_dl_d;
  logic [PID_BITS-1:0] new_pid_q, new_pid_d;

  logic                res_valid_q, res_valid_d;
  logic [KIND_W-1:0]   res_kind_q, res_kind_d;
  logic [PID_W-1:0]    res_pid_q, res_pid_d;
  logic                res_last_q, res_last_d;

  cell_ctl_t           ctl;
  logic                accept;
  logic                full;
  logic                due0, due1;
  logic                rel_last;

  // chain wiring, one spare slot past the end that reads as empty
  logic                cell_valid  [MAX_TIMERS+1];
  logic [TICK_W-1:0]   cell_dl     [MAX_TIMERS+1];
  logic [PID_BITS-1:0] cell_pid    [MAX_TIMERS+1];
  logic                cell_before [MAX_TIMERS];

  assign cell_valid[MAX_TIMERS] = 1'b0;
  assign cell_dl[MAX_TIMERS]    = '0;
  assign cell_pid[MAX_TIMERS]   = '0;

  // the cell chain
  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
    logic                pb;
    logic                pv;
    logic [TICK_W-1:0]   pd;
    logic [PID_BITS-1:0] pp;
    if (i == 0) begin : g_head
      assign pb = 1'b0;
      assign pv = 1'b0;
      assign pd = '0;
      assign pp = '0;
    end else begin : g_body
      assign pb = cell_before[i-1];
      assign pv = cell_valid[i-1];
      assign pd = cell_dl[i-1];
      assign pp = cell_pid[i-1];
    end
    sdtq_cell #(
      .PidW (PID_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_dl_i      (new_dl_q),
      .new_pid_i     (new_pid_q),
      .prev_before_i (pb),
      .prev_valid_i  (pv),
      .prev_dl_i     (pd),
      .prev_pid_i    (pp),
      .next_valid_i  (cell_valid[i+1]),
      .next_dl_i     (cell_dl[i+1]),
      .next_pid_i    (cell_pid[i+1]),
      .before_o      (cell_before[i]),
      .valid_o       (cell_valid[i]),
      .dl_o          (cell_dl[i]),
      .pid_o         (cell_pid[i])
    );
  end

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = cell_valid[MAX_TIMERS-1];

  // front entries that have come due
  assign due0     = cell_valid[0] && (tick_q >= cell_dl[0]);
  assign due1     = cell_valid[1] && (tick_q >= cell_dl[1]);
  assign rel_last = !due1 || (rel_q == REL_W'(MAX_OUT - 1));

  // sequencing, counters and result word
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    sec_d       = sec_q;
    sub_d       = sub_q;
    rel_d       = rel_q;
    new_dl_d    = new_dl_q;
    new_pid_d   = new_pid_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_pid_d   = res_pid_q;
    res_last_d  = res_last_q;
    ctl         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          new_pid_d = PID_BITS'(pid_i);
          if (req_type_i == REQ_ADD) begin
            if (full) begin
              res_valid_d = 1'b1;
              res_kind_d  = KIND_FULL;
              res_pid_d   = PID_W'(PID_BITS'(pid_i));
              res_last_d  = 1'b1;
            end else begin
              new_dl_d = tick_q + TICK_W'(wanted_ticks_i) + TICK_W'(1);
              state_d  = S_INS;
            end
          end else begin
            tick_d = tick_q + TICK_W'(1);
            // wrap of the counter brings seconds back to zero as well
            if (&tick_q) begin
              sec_d = '0;
              sub_d = '0;
            end else if (sub_q == SUB_W'(SECS_DIV - 1)) begin
              sec_d = sec_q + SEC_W'(1);
              sub_d = '0;
            end else begin
              sub_d = sub_q + SUB_W'(1);
            end
            rel_d   = '0;
            state_d = S_REL;
          end
        end
      end
      S_INS: begin
        ctl.ins     = 1'b1;
        res_valid_d = 1'b1;
        res_kind_d  = KIND_ADD;
        res_pid_d   = PID_W'(new_pid_q);
        res_last_d  = 1'b1;
        state_d     = S_IDLE;
      end
      S_REL: begin
        res_valid_d = 1'b1;
        if (due0) begin
          ctl.shift  = 1'b1;
          res_kind_d = KIND_REL;
          res_pid_d  = PID_W'(cell_pid[0]);
          res_last_d = rel_last;
          rel_d      = rel_q + REL_W'(1);
          if (rel_last) begin
            state_d = S_IDLE;
          end
        end else begin
          // nothing due on this tick
          res_kind_d = KIND_TICK;
          res_pid_d  = '0;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      sec_q       <= '0;
      sub_q       <= '0;
      rel_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      sec_q       <= sec_d;
      sub_q       <= sub_d;
      rel_q       <= rel_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    new_dl_q   <= new_dl_d;
    new_pid_q  <= new_pid_d;
    res_kind_q <= res_kind_d;
    res_pid_q  <= res_pid_d;
    res_last_q <= res_last_d;
  end

  // result word; counters only move on accepted ticks, so they match the word
  assign result_valid_o  = res_valid_q;
  assign kind_o          = res_kind_q;
  assign released_pid_o  = res_pid_q;
  assign tick_count_o    = tick_q;
  assign seconds_count_o = sec_q;
  assign last_o          = res_last_q;

endmodule

>>> rtl/core/sdtq_checker.sv
// port-level checks for the sorted deadline timer queue, bound to the top level
`timescale 1ns / 1ps
module sdtq_checker
  import sdtq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [KIND_W-1:0] kind_o,
  input logic [PID_W-1:0]  released_pid_o,
  input logic [TICK_W-1:0] tick_count_o,
  input logic              last_o
);

  // an accepted command is either in work or answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_valid_o)
    else $error("accepted command neither in work nor answered");

  // a release burst that is not finished goes on with another release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && (kind_o == KIND_REL))
    else $error("release burst broken off");

  // plain tick report carries no pid and closes the command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_TICK) |-> (released_pid_o == '0) && last_o)
    else $error("bad plain tick report");

  // add answers are single words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((kind_o == KIND_ADD) || (kind_o == KIND_FULL)) |-> last_o)
    else $error("add answer not marked last");

  // tick count holds while a command is in work without a new tick accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> $stable(tick_count_o))
    else $error("tick count moved during work");

endmodule

bind sorted_deadline_timer_queue_core sdtq_checker u_sdtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .released_pid_o (released_pid_o),
  .tick_count_o   (tick_count_o),
  .last_o         (last_o)
);
